// ===== hdl/pump_interval_scheduler_macros.svh =====
// Assertion macros for the pump interval scheduler.
`ifndef PUMP_INTERVAL_SCHEDULER_MACROS_SVH
`define PUMP_INTERVAL_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pump scheduler assertion failed");
// next-cycle implication
`define PIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pump scheduler assertion failed");
`else
`define PIS_ASSERT_IMP(lbl, ante, cons)
`define PIS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/pis_pkg.sv =====
// Types, constants and helpers shared by the pump interval scheduler.
package pis_pkg;

  localparam int DUR_W      = 19;
  localparam int IVL_W      = 18;
  localparam int LVL_W      = 7;
  localparam int SECS_W     = 32;
  localparam int MS_W       = 32;
  localparam int ECHO_W     = 15;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int DSEC_W     = 10;

  typedef logic [STAT_W-1:0]    status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam status_t ST_NORMAL  = 3'd0;
  localparam status_t ST_QUEUED  = 3'd1;
  localparam status_t ST_STARTED = 3'd2;
  localparam status_t ST_REFUSED = 3'd3;
  localparam status_t ST_SAFETY  = 3'd4;

  localparam cfg_idx_t REG_DURATION  = 2'd0;
  localparam cfg_idx_t REG_INTERVAL  = 2'd1;
  localparam cfg_idx_t REG_LOW_LEVEL = 2'd2;

  localparam logic ACT_TRIGGER = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  localparam logic [ECHO_W-1:0] ECHO_FULL_US    = 15'd291;
  localparam logic [ECHO_W-1:0] ECHO_EMPTY_US   = 15'd1750;
  localparam logic [22:0]       LEVEL_OFFSET_Q16 = 23'd7864320;
  localparam logic [12:0]       LEVEL_SLOPE_Q16  = 13'd4496;
  localparam logic [LVL_W-1:0]  LEVEL_FULL      = 7'd100;
  localparam logic [LVL_W-1:0]  LEVEL_EMPTY     = 7'd0;

  localparam logic [DUR_W-1:0]  DUR_RST  = 19'd30000;
  localparam logic [IVL_W-1:0]  IVL_RST  = 18'd43200;
  localparam logic [LVL_W-1:0]  LOW_RST  = 7'd10;
  localparam logic [DSEC_W-1:0] DSEC_RST = 10'd30;

  // x / 1000 == (x * 536871) >> 29 for every 19-bit x
  localparam logic [19:0] DIV1000_MUL   = 20'd536871;
  localparam int          DIV1000_SHIFT = 29;

  typedef struct packed {
    logic              action;
    logic [SECS_W-1:0] now_secs;
    logic [MS_W-1:0]   now_ms;
    logic [ECHO_W-1:0] echo_us;
  } in_item_t;

  typedef struct packed {
    logic             pump_on;
    logic [LVL_W-1:0] level_percent;
    logic             send_now;
    status_t          status;
  } out_item_t;

  function automatic logic [LVL_W-1:0] echo_to_level(input logic [ECHO_W-1:0] echo);
    logic [27:0] prod;
    logic [27:0] diff;
    logic [LVL_W-1:0] lvl;
    prod = {13'd0, echo} * {15'd0, LEVEL_SLOPE_Q16};
    diff = {5'd0, LEVEL_OFFSET_Q16} - prod;
    if (echo <= ECHO_FULL_US) begin
      lvl = LEVEL_FULL;
    end else if (echo >= ECHO_EMPTY_US) begin
      lvl = LEVEL_EMPTY;
    end else begin
      lvl = diff[22:16];
    end
    return lvl;
  endfunction

endpackage

// ===== hdl/pis_in_if.sv =====
// Input channel: trigger and tick words.
interface pis_in_if;
  import pis_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [SECS_W-1:0] now_secs;
  logic [MS_W-1:0]   now_ms;
  logic [ECHO_W-1:0] echo_us;

  modport source (output valid, output action, output now_secs, output now_ms,
                  output echo_us, input ready);
  modport sink   (input valid, input action, input now_secs, input now_ms,
                  input echo_us, output ready);
endinterface

// ===== hdl/pis_out_if.sv =====
// Result channel: pump drive, level and report status.
interface pis_out_if;
  import pis_pkg::*;

  logic             valid;
  logic             ready;
  logic             pump_on;
  logic [LVL_W-1:0] level_percent;
  logic             send_now;
  status_t          status;

  modport source (output valid, output pump_on, output level_percent,
                  output send_now, output status, input ready);
  modport sink   (input valid, input pump_on, input level_percent,
                  input send_now, input status, output ready);
endinterface

// ===== hdl/pis_cfg_if.sv =====
// Configuration write channel.
interface pis_cfg_if;
  import pis_pkg::*;

  logic                  valid;
  logic                  ready;
  cfg_idx_t              idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== hdl/pump_interval_scheduler.sv =====
// Pump interval scheduler top level.
// Path from input accept to result valid: input register, then result register.
// Throughput: one word per cycle while the output is ready; input stage refills while a result waits.
// State update and result are formed in one pass through the level map multiplier.
// Reset (rst_n low, synchronous): pump off, no trigger pending, level 0,
// timestamps 0, registers at 30000 ms / 43200 s / 10 %.
`include "pump_interval_scheduler_macros.svh"

module pump_interval_scheduler (
  input logic       clk,
  input logic       rst_n,
  pis_in_if.sink    in_ch,
  pis_out_if.source out_ch,
  pis_cfg_if.sink   cfg_ch
);
  import pis_pkg::*;

  logic in_vld_r, in_vld_nxt;
  in_item_t in_r;
  logic out_vld_r, out_vld_nxt;
  out_item_t out_r, res;

  logic [DUR_W-1:0]  dur_r;
  logic [IVL_W-1:0]  ivl_r;
  logic [LVL_W-1:0]  low_r;
  logic [DSEC_W-1:0] dsec_r;
  logic [38:0]       dsec_prod;

  logic              pump_r, pump_nxt;
  logic              pend_r, pend_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [SECS_W-1:0] last_r, last_nxt;
  logic [MS_W-1:0]   start_r, start_nxt;

  logic              advance, fire, in_acc;
  logic [LVL_W-1:0]  level_cand;
  logic              low;
  logic [SECS_W-1:0] diff_secs;
  logic              sched;
  logic              active;
  logic [MS_W-1:0]   base_ms, end_ms;

  assign advance = !out_vld_r || out_ch.ready;
  assign fire    = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;
  assign in_acc  = in_ch.valid && in_ch.ready;

  assign in_vld_nxt  = in_acc ? 1'b1 : (fire ? 1'b0 : in_vld_r);
  assign out_vld_nxt = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  assign cfg_ch.ready = 1'b1;
  assign dsec_prod = {20'd0, cfg_ch.data[DUR_W-1:0]} * {19'd0, DIV1000_MUL};

  assign level_cand = (in_r.echo_us != '0) ? echo_to_level(in_r.echo_us) : level_r;
  assign low        = level_cand < low_r;
  assign diff_secs  = in_r.now_secs - last_r;
  assign sched      = diff_secs >= {{(SECS_W-IVL_W){1'b0}}, ivl_r};
  assign active     = sched || (diff_secs <= {{(SECS_W-DSEC_W){1'b0}}, dsec_r});
  assign base_ms    = sched ? in_r.now_ms : start_r;
  assign end_ms     = base_ms + {{(MS_W-DUR_W){1'b0}}, dur_r};

  always_comb begin
    pump_nxt  = pump_r;
    pend_nxt  = pend_r;
    level_nxt = level_r;
    last_nxt  = last_r;
    start_nxt = start_r;
    res.send_now = 1'b0;
    res.status   = ST_NORMAL;
    if (fire) begin
      if (in_r.action == ACT_TRIGGER) begin
        pend_nxt   = 1'b1;
        res.status = ST_QUEUED;
      end else begin
        level_nxt = level_cand;
        if (pend_r) begin
          pend_nxt = 1'b0;
          if (low) begin
            res.status = ST_REFUSED;
          end else begin
            pump_nxt     = 1'b1;
            start_nxt    = in_r.now_ms;
            last_nxt     = in_r.now_secs;
            res.send_now = 1'b1;
            res.status   = ST_STARTED;
          end
        end else if (low && pump_r) begin
          pump_nxt     = 1'b0;
          res.send_now = 1'b1;
          res.status   = ST_SAFETY;
        end else begin
          if (sched) begin
            last_nxt     = in_r.now_secs;
            start_nxt    = in_r.now_ms;
            res.send_now = 1'b1;
          end
          if (active) begin
            if (in_r.now_ms > end_ms && pump_r) begin
              pump_nxt     = 1'b0;
              res.send_now = 1'b1;
            end else if (in_r.now_ms < end_ms && !pump_r) begin
              pump_nxt = 1'b1;
            end
          end else if (pump_r) begin
            pump_nxt     = 1'b0;
            res.send_now = 1'b1;
          end
        end
      end
    end
    res.pump_on       = pump_nxt;
    res.level_percent = level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pump_r    <= 1'b0;
      pend_r    <= 1'b0;
      level_r   <= '0;
      last_r    <= '0;
      start_r   <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      pump_r    <= pump_nxt;
      pend_r    <= pend_nxt;
      level_r   <= level_nxt;
      last_r    <= last_nxt;
      start_r   <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r.action   <= in_ch.action;
      in_r.now_secs <= in_ch.now_secs;
      in_r.now_ms   <= in_ch.now_ms;
      in_r.echo_us  <= in_ch.echo_us;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r  <= DUR_RST;
      ivl_r  <= IVL_RST;
      low_r  <= LOW_RST;
      dsec_r <= DSEC_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        REG_DURATION: begin
          dur_r  <= cfg_ch.data[DUR_W-1:0];
          dsec_r <= dsec_prod[DIV1000_SHIFT+DSEC_W-1:DIV1000_SHIFT];
        end
        REG_INTERVAL:  ivl_r <= cfg_ch.data[IVL_W-1:0];
        REG_LOW_LEVEL: low_r <= cfg_ch.data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.pump_on       = out_r.pump_on;
  assign out_ch.level_percent = out_r.level_percent;
  assign out_ch.send_now      = out_r.send_now;
  assign out_ch.status        = out_r.status;

  `PIS_ASSERT_NXT(a_trigger_pends, fire && in_r.action == ACT_TRIGGER, pend_r)
  `PIS_ASSERT_IMP(a_safety_off, out_vld_r && out_r.status == ST_SAFETY, !out_r.pump_on)
  `PIS_ASSERT_NXT(a_pump_held, !fire, pump_r == $past(pump_r))
  `PIS_ASSERT_IMP(a_no_drop, in_vld_r && !advance, !in_ch.ready)

endmodule
